/* rtl/core/bed_pkg.sv */
// ----------------------------------------------------------------------------
// Backslash escape decoder package
// Shared types, character constants and decode functions.
// ----------------------------------------------------------------------------
`default_nettype none

package bed_pkg;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_HEX1   = 2'd2;
    localparam logic [1:0] MODE_HEX2   = 2'd3;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X         = 8'h78;

    typedef struct packed {
        logic       has_result;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       bad_escape;
        logic       end_of_string;
    } bed_result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } bed_hex_t;

    function automatic bed_hex_t hex_digit(input logic [7:0] c);
        bed_hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.value = 4'(c - 8'h37);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [7:0] escape_code(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            8'h61:   r = 8'd7;
            8'h62:   r = 8'd8;
            8'h66:   r = 8'd12;
            8'h6E:   r = 8'd10;
            8'h72:   r = 8'd13;
            8'h74:   r = 8'd9;
            8'h76:   r = 8'd11;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bed_in_stage.sv */
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted transaction until the decode stage advances.
// ----------------------------------------------------------------------------
`default_nettype none

module bed_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       is_end,
    input  wire logic       advance,
    output logic            held_valid,
    output logic [7:0]      held_byte,
    output logic            held_end
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;

    assign item_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_ready)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            byte_reg <= in_byte;
            end_reg  <= is_end;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_end   = end_reg;

endmodule

`default_nettype wire

/* rtl/core/bed_decode.sv */
// ----------------------------------------------------------------------------
// Escape decode stage
// Holds the escape mode, pending high nibble and error flag, and forms the
// result of the held byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bed_decode (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [7:0]          in_byte,
    input  wire logic                is_end,
    output bed_pkg::bed_result_t     result
);
    import bed_pkg::*;

    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic [3:0] nibble_reg;
    logic [3:0] nibble_next;
    logic       err_reg;
    logic       err_next;
    bed_hex_t   hex;

    assign hex = hex_digit(in_byte);

    always_comb
    begin
        result      = '0;
        mode_next   = mode_reg;
        nibble_next = nibble_reg;
        err_next    = err_reg;
        if (is_end)
        begin
            result.has_result    = 1'b1;
            result.end_of_string = 1'b1;
            result.bad_escape    = err_reg || (mode_reg != MODE_NORMAL);
            mode_next            = MODE_NORMAL;
            nibble_next          = 4'd0;
            err_next             = 1'b0;
        end
        else if (!err_reg)
        begin
            unique case (mode_reg)
                MODE_NORMAL:
                begin
                    if (in_byte == CHAR_BACKSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        result.has_result = 1'b1;
                        result.byte_valid = 1'b1;
                        result.out_byte   = in_byte;
                    end
                end
                MODE_ESC:
                begin
                    if (in_byte == CHAR_X)
                    begin
                        mode_next = MODE_HEX1;
                    end
                    else
                    begin
                        mode_next         = MODE_NORMAL;
                        result.has_result = 1'b1;
                        result.byte_valid = 1'b1;
                        result.out_byte   = escape_code(in_byte);
                    end
                end
                MODE_HEX1:
                begin
                    if (hex.ok)
                    begin
                        nibble_next = hex.value;
                        mode_next   = MODE_HEX2;
                    end
                    else
                    begin
                        err_next  = 1'b1;
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_HEX2:
                begin
                    mode_next = MODE_NORMAL;
                    if (hex.ok)
                    begin
                        result.has_result = 1'b1;
                        result.byte_valid = 1'b1;
                        result.out_byte   = {nibble_reg, hex.value};
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            nibble_reg <= 4'd0;
            err_reg    <= 1'b0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            nibble_reg <= nibble_next;
            err_reg    <= err_next;
        end
    end

`ifndef SYNTHESIS
    a_err_in_normal: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> (mode_reg == MODE_NORMAL))
        else $error("error flag set outside normal mode");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_end) |=> (mode_reg == MODE_NORMAL && !err_reg))
        else $error("terminator did not clear decode state");
    a_bad_only_end: assert property (@(posedge clk) disable iff (!rst_n)
        result.bad_escape |-> (result.end_of_string && !result.byte_valid))
        else $error("bad escape flagged on a byte result");
    a_drop_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg && !is_end) |-> !result.has_result)
        else $error("byte produced after an error");
`endif

endmodule

`default_nettype wire

/* rtl/core/bed_out_stage.sv */
// ----------------------------------------------------------------------------
// Result register
// Holds one decoded result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bed_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load_valid,
    input  wire bed_pkg::bed_result_t load_result,
    output logic                      advance,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output logic [7:0]                out_byte,
    output logic                      byte_valid,
    output logic                      bad_escape,
    output logic                      end_of_string
);
    import bed_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    bed_result_t data_reg;

    assign advance = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = load_valid && load_result.has_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_valid && load_result.has_result)
        begin
            data_reg <= load_result;
        end
    end

    assign result_valid  = valid_reg;
    assign out_byte      = data_reg.out_byte;
    assign byte_valid    = data_reg.byte_valid;
    assign bad_escape    = data_reg.bad_escape;
    assign end_of_string = data_reg.end_of_string;

endmodule

`default_nettype wire

/* rtl/core/backslash_escape_decoder.sv */
// ----------------------------------------------------------------------------
// Backslash escape decoder
// Decodes C-style backslash escapes in a byte stream, one byte per cycle.
//
// The item channel (item_valid/item_ready) carries in_byte and is_end; a
// transaction with is_end high terminates the string. The result channel
// (result_valid/result_ready) carries out_byte, byte_valid, bad_escape and
// end_of_string. Only the last byte of an escape can produce a result, and
// after a malformed hex escape all bytes are dropped until the terminator,
// whose result then reports bad_escape.
// The input register takes an accepted transaction; the decoded result of
// the held transaction is loaded into the result register once that register
// can advance, and a transaction without a result loads nothing. One
// transaction is accepted per cycle as long as the receiver keeps up.
// When result_ready is low with a result waiting, the result register holds
// and an empty input register still takes one more transaction; item_ready
// then falls until the result is taken. Reset empties both registers and
// returns the decoder to normal mode with the error flag clear.
// ----------------------------------------------------------------------------
`default_nettype none

module backslash_escape_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       is_end,
    output logic            result_valid,
    input  wire logic       result_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            bad_escape,
    output logic            end_of_string
);
    import bed_pkg::*;

    logic        advance;
    logic        held_valid;
    logic [7:0]  held_byte;
    logic        held_end;
    bed_result_t result;

    bed_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .in_byte    (in_byte),
        .is_end     (is_end),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_end   (held_end)
    );

    bed_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (held_valid && advance),
        .in_byte (held_byte),
        .is_end  (held_end),
        .result  (result)
    );

    bed_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_valid    (held_valid),
        .load_result   (result),
        .advance       (advance),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .bad_escape    (bad_escape),
        .end_of_string (end_of_string)
    );

endmodule

`default_nettype wire
